### hdl/sqmm_pkg.sv
// Shared widths, opcodes and controller/datapath interface types for the matrix multiplier.
package sqmm_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int SIZE_W = 5;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 36;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_C    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic start;  // latch size, clear loop counters
    logic step;   // issue one multiply-accumulate
    logic wr_a;   // store request element into A
    logic wr_b;   // store request element into B
    logic rd_c;   // read one product element
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_zero;      // configured size is zero
    logic last_issue;  // loop counters sit on the final term
    logic pipe_busy;   // multiply-accumulate pipeline holds work
    logic room;        // result queue can take one more read
  } sts_t;

endpackage

### hdl/square_matrix_multiply.sv
// A read's product is registered by the product store read port, then by the result queue head.
//   Writes go 1 per cycle while requests are taken; a read may be taken while another is in
//   flight, but it counts against the two-entry result queue and any request waits while the
//   queue is full or owed; a compute of size n > 0 blocks requests until its n*n*n terms drain.
// Reset: size register returns to 16; product elements read as zero until the first compute,
//   with no clearing pass; A and B hold no defined value until written.
module square_matrix_multiply #(
  parameter int MAX_DIM = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sqmm_pkg::OP_W-1:0]         in_op,
  input  logic [sqmm_pkg::IDX_W-1:0]        in_row,
  input  logic [sqmm_pkg::IDX_W-1:0]        in_col,
  input  logic signed [sqmm_pkg::ELEM_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sqmm_pkg::ACC_W-1:0] out_product_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sqmm_pkg::SIZE_W-1:0]       cfg_data
);
  import sqmm_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  cmd_t              cmd;
  sts_t              sts;
  logic [SIZE_W-1:0] size_r;

  // Size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  sqmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  sqmm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .size_in_use       (size_r),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value)
  );

  // No request is taken while the multiply-accumulate pipeline holds work
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !sts.pipe_busy)
    else $error("request accepted during compute");

  // A compute with nonzero size blocks the next request
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !sts.n_zero) |=> !in_ready)
    else $error("compute start did not block requests");

  // Full result queue blocks requests
  assert property (@(posedge clk) disable iff (!rst_n) !sts.room |-> !in_ready)
    else $error("request accepted with result queue full");

  // Multiply steps never overlap request traffic
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !(cmd.wr_a || cmd.wr_b || cmd.rd_c || cmd.start))
    else $error("compute step overlaps a request");

endmodule

### hdl/sqmm_ram.sv
// Generic simple dual-port RAM with registered read data.
module sqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/sqmm_ctrl.sv
// Controller state machine: request acceptance and compute sequencing.
module sqmm_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [sqmm_pkg::OP_W-1:0] in_op,
  input  sqmm_pkg::sts_t          sts,
  output sqmm_pkg::cmd_t          cmd
);
  import sqmm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Take requests only while idle and the result queue has space
  assign in_ready = (state_r == ST_IDLE) && sts.room;
  assign accept   = in_valid && in_ready;

  // Decode commands
  always_comb begin
    cmd       = '0;
    cmd.wr_a  = accept && (in_op == OP_WR_A);
    cmd.wr_b  = accept && (in_op == OP_WR_B);
    cmd.start = accept && (in_op == OP_COMPUTE);
    cmd.rd_c  = accept && (in_op == OP_RD_C);
    cmd.step  = (state_r == ST_ISSUE);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start && !sts.n_zero) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/sqmm_dp.sv
// Datapath: matrix stores, loop counters, multiply-accumulate pipeline, result queue.
module sqmm_dp #(
  parameter int MAX_DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sqmm_pkg::cmd_t                cmd,
  output sqmm_pkg::sts_t                sts,
  input  logic [sqmm_pkg::SIZE_W-1:0]   size_in_use,
  input  logic [sqmm_pkg::IDX_W-1:0]    in_row,
  input  logic [sqmm_pkg::IDX_W-1:0]    in_col,
  input  logic signed [sqmm_pkg::ELEM_W-1:0] in_element_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [sqmm_pkg::ACC_W-1:0]  out_product_value
);
  import sqmm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  // Size clamp and request address
  logic [NW-1:0] n_eff;
  logic          req_inside;
  logic [AW-1:0] req_addr;

  assign n_eff      = (32'(size_in_use) > MAX_DIM) ? NW'(MAX_DIM) : NW'(size_in_use);
  assign req_inside = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign req_addr   = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

  // Size used by the last compute; product entries outside it read as zero
  logic [NW-1:0] c_dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_dim_r <= '0;
    end else if (cmd.start) begin
      c_dim_r <= n_eff;
    end
  end

  // Loop counters over row, column and inner term
  logic [IW-1:0] i_r, j_r, k_r;
  logic          i_last, j_last, k_last;

  assign i_last = (NW'(i_r) + NW'(1)) == c_dim_r;
  assign j_last = (NW'(j_r) + NW'(1)) == c_dim_r;
  assign k_last = (NW'(k_r) + NW'(1)) == c_dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else if (cmd.step) begin
      if (k_last) begin
        k_r <= '0;
        if (j_last) begin
          j_r <= '0;
          i_r <= i_r + IW'(1);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end else begin
        k_r <= k_r + IW'(1);
      end
    end
  end

  // Source stores
  logic [AW-1:0]     a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  assign a_raddr = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_raddr = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a && req_inside),
    .waddr (req_addr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b && req_inside),
    .waddr (req_addr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Stage 1: operands arrive from the stores
  logic          s1_valid_r, s1_first_r, s1_last_r;
  logic [AW-1:0] s1_caddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= k_last;
    s1_caddr_r <= AW'(i_r) * AW'(MAX_DIM) + AW'(j_r);
  end

  // Stage 2: registered product
  logic                     s2_valid_r, s2_first_r, s2_last_r;
  logic [AW-1:0]            s2_caddr_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_caddr_r <= s1_caddr_r;
    prod_r     <= $signed(a_rdata) * $signed(b_rdata);
  end

  // Stage 3: accumulate, restart on the first term of each element
  logic                    s3_valid_r, s3_last_r;
  logic [AW-1:0]           s3_caddr_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_last_r  <= s2_last_r;
    s3_caddr_r <= s2_caddr_r;
    if (s2_valid_r) begin
      acc_r <= s2_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // Product store: written by the pipeline, read by requests
  logic [ACC_W-1:0] c_rdata;

  sqmm_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_ram_c (
    .clk   (clk),
    .we    (s3_valid_r && s3_last_r),
    .waddr (s3_caddr_r),
    .wdata (acc_r),
    .raddr (req_addr),
    .rdata (c_rdata)
  );

  // Read in flight; zero when outside the last computed size
  logic rd_pend_r, rd_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_c;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero_r <= !((32'(in_row) < 32'(c_dim_r)) && (32'(in_col) < 32'(c_dim_r)));
  end

  // Two-entry result queue: head drives the output, tail holds a second result
  logic [ACC_W-1:0] head_r, head_nxt, tail_r, tail_nxt, push_data;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign push      = rd_pend_r;
  assign pop       = out_valid && out_ready;
  assign push_data = rd_zero_r ? '0 : c_rdata;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          tail_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_product_value = head_r;

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.n_zero     = (n_eff == '0);
    sts.last_issue = i_last && j_last && k_last;
    sts.pipe_busy  = s1_valid_r || s2_valid_r || s3_valid_r;
    sts.room       = ({1'b0, cnt_r} + {2'b00, rd_pend_r}) < 3'd2;
  end

endmodule

### bench/sqmm_product_checker.sv
// Channel monitor with product predictor and result scoreboard for the matrix multiplier.
`timescale 1ns / 1ps
module sqmm_product_checker #(
  parameter int MAX_DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [sqmm_pkg::OP_W-1:0]          in_op,
  input  logic [sqmm_pkg::IDX_W-1:0]         in_row,
  input  logic [sqmm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [sqmm_pkg::ELEM_W-1:0] in_element_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [sqmm_pkg::ACC_W-1:0]  out_product_value,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [sqmm_pkg::SIZE_W-1:0]        cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import sqmm_pkg::*;

  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int RESET_DIM = 16;

  // Shadow copies of the three matrices and the size register
  logic signed [ELEM_W-1:0] a_store [CELLS];
  logic signed [ELEM_W-1:0] b_store [CELLS];
  logic signed [ACC_W-1:0]  c_store [CELLS];
  logic [SIZE_W-1:0]        dim_reg;

  // Product values still owed by the block, oldest first
  logic signed [ACC_W-1:0]  product_q [$];
  int                       fails = 0;

  // Clear the product store, then form C = A x B over the active size
  task automatic form_product();
    int     n;
    longint acc;
    n = (int'(dim_reg) > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    for (int i = 0; i < CELLS; i++) c_store[i] = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_store[i * MAX_DIM + k]) * longint'(b_store[k * MAX_DIM + j]);
        end
        c_store[i * MAX_DIM + j] = acc[ACC_W-1:0];
      end
    end
  endtask

  always @(posedge clk) begin : watch
    logic signed [ACC_W-1:0] want;
    int                      r;
    int                      c;
    bit                      in_range;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        a_store[i] = '0;
        b_store[i] = '0;
        c_store[i] = '0;
      end
      dim_reg = SIZE_W'(RESET_DIM);
      product_q.delete();
    end else begin
      // Match each delivered result against the oldest owed product
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          $error("product_value with no read request waiting: actual %0d", out_product_value);
          fails++;
        end else begin
          want = product_q.pop_front();
          if (out_product_value !== want) begin
            $error("product_value mismatch: expected %0d, actual %0d", want, out_product_value);
            fails++;
          end
        end
      end

      // Track size register writes
      if (cfg_valid && cfg_ready) dim_reg = cfg_data;

      // Apply each accepted request to the shadow state
      if (in_valid && in_ready) begin
        r = int'(in_row);
        c = int'(in_col);
        in_range = (r < MAX_DIM) && (c < MAX_DIM);
        case (in_op)
          OP_WR_A: begin
            if (in_range) a_store[r * MAX_DIM + c] = in_element_value;
          end
          OP_WR_B: begin
            if (in_range) b_store[r * MAX_DIM + c] = in_element_value;
          end
          OP_COMPUTE: begin
            form_product();
          end
          OP_RD_C: begin
            product_q.push_back(in_range ? c_store[r * MAX_DIM + c] : '0);
          end
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= product_q.size();
  end

endmodule

### bench/tb_square_matrix_multiply.sv
// Top-level bench for the matrix multiplier: clock, reset, request stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_square_matrix_multiply;
  import sqmm_pkg::*;

  localparam int MAX_DIM     = 16;
  localparam int CELLS       = MAX_DIM * MAX_DIM;
  localparam int QUIET_LIMIT = 50000;
  localparam int PHASE_REQS  = 120;
  localparam int SETTLE_PAD  = 16;
  localparam int INDEX_TOP   = (1 << IDX_W) - 1;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            in_op            = OP_WR_A;
  logic [IDX_W-1:0]           in_row           = '0;
  logic [IDX_W-1:0]           in_col           = '0;
  logic signed [ELEM_W-1:0]   in_element_value = '0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic signed [ACC_W-1:0]    out_product_value;
  logic                       cfg_valid        = 1'b0;
  logic                       cfg_ready;
  logic [SIZE_W-1:0]          cfg_data         = '0;

  int                         fail_count;
  int                         pending;

  // Pacing knobs, in percent of cycles, and the quiet-cycle counter
  int                         idle_pct         = 0;
  int                         stall_pct        = 0;
  int                         quiet_cycles     = 0;

  // Source entries written so far, so a compute never reads an undefined one
  bit                         written_a [CELLS];
  bit                         written_b [CELLS];
  logic [SIZE_W-1:0]          cur_size         = SIZE_W'(16);
  int                         last_dim         = 0;
  int                         sent_reqs        = 0;
  int                         read_reqs        = 0;
  int                         compute_reqs     = 0;
  int                         size_writes      = 0;
  logic [SIZE_W-1:0]          size_plan [8]    = '{5'd3, 5'd1, 5'd16, 5'd0,
                                                   5'd31, 5'd5, 5'd17, 5'd2};

  square_matrix_multiply #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_product_value(out_product_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  sqmm_product_checker #(
    .MAX_DIM(MAX_DIM)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_product_value(out_product_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Count cycles in which no channel moves a request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int active_dim(input logic [SIZE_W-1:0] n);
    return (int'(n) > MAX_DIM) ? MAX_DIM : int'(n);
  endfunction

  // Mostly inside the active square, sometimes anywhere in the index range
  function automatic logic [IDX_W-1:0] pick_index(input int n);
    if (n > 0 && $urandom_range(99) < 80) return IDX_W'($urandom_range(n - 1, 0));
    return IDX_W'($urandom_range(INDEX_TOP, 0));
  endfunction

  // Random element, with the range extremes mixed in
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(39))
      0:       return {1'b1, {(ELEM_W-1){1'b0}}};
      1:       return {1'b0, {(ELEM_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                          input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_row           <= row;
    in_col           <= col;
    in_element_value <= value;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sent_reqs++;
    case (op)
      OP_WR_A:    written_a[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      OP_WR_B:    written_b[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      OP_COMPUTE: compute_reqs++;
      OP_RD_C:    read_reqs++;
      default:    ;
    endcase
  endtask

  // Load any source entry of the active square not yet written, then compute
  task automatic run_compute();
    int n;
    n = active_dim(cur_size);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!written_a[r * MAX_DIM + c]) send_req(OP_WR_A, IDX_W'(r), IDX_W'(c), pick_element());
        if (!written_b[r * MAX_DIM + c]) send_req(OP_WR_B, IDX_W'(r), IDX_W'(c), pick_element());
      end
    end
    send_req(OP_COMPUTE, pick_index(0), pick_index(0), pick_element());
    last_dim = n;
  endtask

  // Drop valid, wait for every owed product, then let a trailing compute finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (last_dim * last_dim * last_dim + SETTLE_PAD) @(posedge clk);
  endtask

  // Write the size register while the block is idle
  task automatic write_size(input logic [SIZE_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_size = value;
    size_writes++;
  endtask

  // Random traffic: element loads, occasional computes, product reads
  task automatic run_phase(input int reqs);
    int n;
    int kind;
    int stop_at;
    n = active_dim(cur_size);
    stop_at = sent_reqs + reqs;
    while (sent_reqs < stop_at) begin
      kind = $urandom_range(99);
      if (kind < ((n >= 8) ? 2 : 6)) begin
        run_compute();
      end else if (kind < 62) begin
        send_req(($urandom_range(1) == 0) ? OP_WR_A : OP_WR_B,
                 pick_index(n), pick_index(n), pick_element());
      end else begin
        send_req(OP_RD_C, pick_index(n), pick_index(n), pick_element());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Product store reads zero straight out of reset
    send_req(OP_RD_C, '0, '0, pick_element());
    send_req(OP_RD_C, '1, '1, pick_element());

    // 2x2 product at the element extremes, plus entries outside the active square
    write_size(SIZE_W'(2));
    send_req(OP_WR_A, 4'd0, 4'd0, 16'sh8000);
    send_req(OP_WR_A, 4'd0, 4'd1, 16'sh8000);
    send_req(OP_WR_A, 4'd1, 4'd0, 16'sh7fff);
    send_req(OP_WR_A, 4'd1, 4'd1, 16'sh0000);
    send_req(OP_WR_B, 4'd0, 4'd0, 16'sh8000);
    send_req(OP_WR_B, 4'd1, 4'd0, 16'sh8000);
    send_req(OP_WR_B, 4'd0, 4'd1, 16'sh7fff);
    send_req(OP_WR_B, 4'd1, 4'd1, 16'shffff);
    send_req(OP_WR_A, '1, '1, 16'sh7fff);
    send_req(OP_WR_B, '1, '1, 16'sh8000);
    run_compute();
    send_req(OP_RD_C, 4'd0, 4'd0, pick_element());
    send_req(OP_RD_C, 4'd0, 4'd1, pick_element());
    send_req(OP_RD_C, 4'd1, 4'd0, pick_element());
    send_req(OP_RD_C, 4'd1, 4'd1, pick_element());
    send_req(OP_RD_C, '1, '1, pick_element());
    send_req(OP_RD_C, '1, '0, pick_element());

    // Size zero: compute only makes every product entry read as zero
    write_size('0);
    run_compute();
    send_req(OP_RD_C, 4'd1, 4'd1, pick_element());

    // Random phases over several sizes and pacing modes
    for (int p = 0; p < 8; p++) begin
      write_size(size_plan[p]);
      idle_pct  = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 33 : 0;
      stall_pct = (p % 4 == 2) ? 56 : (p % 4 == 3) ? 33 : 0;
      run_compute();
      run_phase(PHASE_REQS);
    end

    settle();
    $display("Run covered %0d requests: %0d product reads, %0d computes, %0d size writes.",
             sent_reqs, read_reqs, compute_reqs, size_writes);
    $display("Sizes 0 through 31 incl. saturation; back to back, sender gaps, receiver stalls.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
